### hdl/serial_terminal_register_unit_defines.svh
// assertion macros for the serial terminal register unit
// used by serial_terminal_register_unit, which carries concurrent checks; no other dependencies
`ifndef SERIAL_TERMINAL_REGISTER_UNIT_DEFINES_SVH
`define SERIAL_TERMINAL_REGISTER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// implication or plain property checked on every rising clock edge out of reset
`define STRU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be true on a rising clock edge out of reset
`define STRU_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define STRU_ASSERT(label, prop, msg)
`define STRU_ASSERT_NEVER(label, expr, msg)

`endif

`endif

### hdl/stru_pkg.sv
// shared types and constants of the serial terminal register unit
// no dependencies; imported by stru_line_ram and serial_terminal_register_unit
package stru_pkg;

    // field widths
    localparam int ADDR_W  = 20;
    localparam int DATA_W  = 32;
    localparam int BYTE_W  = 8;
    localparam int OFS_W   = 12;
    localparam int LINE_W  = ADDR_W - OFS_W;
    localparam int CNT_W   = 2;
    localparam int IRQ_W   = 2;

    // register offsets inside one line's window
    localparam logic [OFS_W-1:0] OFS_RX_CTRL = 12'h000;
    localparam logic [OFS_W-1:0] OFS_RX_DATA = 12'h004;
    localparam logic [OFS_W-1:0] OFS_TX_CTRL = 12'h008;
    localparam logic [OFS_W-1:0] OFS_TX_DATA = 12'h00C;

    // control register bit positions
    localparam int BIT_RDY = 0;
    localparam int BIT_IEN = 1;

    // terminal count after reset
    localparam logic [CNT_W-1:0] TERM_COUNT_RESET = 2'd2;

    // item kinds
    typedef enum logic [1:0] {
        KIND_READ    = 2'd0,
        KIND_WRITE   = 2'd1,
        KIND_RX_CHAR = 2'd2,
        KIND_TX_DONE = 2'd3
    } kind_t;

    // decoded operation carried into the modify stage
    typedef enum logic [3:0] {
        OP_NONE    = 4'd0,
        OP_ERROR   = 4'd1,
        OP_RD_RXC  = 4'd2,
        OP_RD_RXD  = 4'd3,
        OP_RD_TXC  = 4'd4,
        OP_WR_RXC  = 4'd5,
        OP_WR_TXC  = 4'd6,
        OP_WR_TXD  = 4'd7,
        OP_EV_RX   = 4'd8,
        OP_EV_TXD  = 4'd9
    } op_t;

    // one line's state as held in the line ram
    typedef struct packed {
        logic              rx_ready;
        logic              rx_int_enable;
        logic [BYTE_W-1:0] rx_byte;
        logic              tx_ready;
        logic              tx_int_enable;
        logic [BYTE_W-1:0] tx_byte_held;
    } line_state_t;

    localparam line_state_t LINE_RESET = '{
        rx_ready:      1'b0,
        rx_int_enable: 1'b0,
        rx_byte:       8'h00,
        tx_ready:      1'b1,
        tx_int_enable: 1'b0,
        tx_byte_held:  8'h00
    };

endpackage

### hdl/stru_line_ram.sv
// per-line state memory with one write and one registered read port
// depends on stru_pkg; unwritten entries read as the line reset state
module stru_line_ram
    import stru_pkg::*;
#(
    parameter int DEPTH = 2,
    parameter int IDX_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_idx,
    output line_state_t       rd_data,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_idx,
    input  line_state_t       wr_data
);

    line_state_t      mem_reg [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    line_state_t      rd_data_reg;
    logic             rd_valid_reg;

    // storage array
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_idx];
        end
    end

    // written flags, cleared by reset so the whole ram reads as reset state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_idx];
            end
        end
    end

    // substitute reset state for entries never written
    assign rd_data = rd_valid_reg ? rd_data_reg : LINE_RESET;

endmodule

### hdl/serial_terminal_register_unit.sv
// Serial terminal register unit: bus register front end for up to MAX_LINES lines.
// Pipeline: ram read and modify stage registers, then modify/commit into the output register.
// Throughput: one item per cycle while out_stall does not hold the output register; set by
// the single read-modify-write path through the line state ram, with a bypass for
// back-to-back items on the same line. Reset: asynchronous, active low; line state returns
// to reset values at once through per-entry written flags, so no clearing pass runs and items are taken right away.
`include "serial_terminal_register_unit_defines.svh"

module serial_terminal_register_unit
    import stru_pkg::*;
#(
    parameter int MAX_LINES = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration
    input  logic              cfg_wr_en,
    input  logic [CNT_W-1:0]  cfg_wr_data,
    // input channel
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        kind,
    input  logic [ADDR_W-1:0] address,
    input  logic [DATA_W-1:0] write_data,
    input  logic              line_index,
    input  logic [BYTE_W-1:0] rx_char,
    // output channel
    output logic              out_valid,
    input  logic              out_stall,
    output logic [BYTE_W-1:0] read_data,
    output logic              bus_error,
    output logic              tx_valid,
    output logic [BYTE_W-1:0] tx_byte,
    output logic [IRQ_W-1:0]  rx_irq_lines,
    output logic [IRQ_W-1:0]  tx_irq_lines
);

    localparam int IDX_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;

    // configuration register
    logic [CNT_W-1:0] term_count_reg;

    // decode stage signals
    logic              in_xfer;
    logic [LINE_W-1:0] bus_line;
    logic [OFS_W-1:0]  bus_ofs;
    logic [LINE_W-1:0] count_ext;
    logic              bus_line_ok;
    logic              ev_line_ok;
    op_t               dec_op;
    logic [LINE_W-1:0] dec_line;
    logic [IDX_W-1:0]  dec_idx;
    logic [BYTE_W-1:0] dec_byte;

    // modify stage registers
    logic              s1_valid_reg;
    op_t               s1_op_reg;
    logic [LINE_W-1:0] s1_line_reg;
    logic [IDX_W-1:0]  s1_idx_reg;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              byp_valid_reg;
    logic              byp_valid_next;
    line_state_t       byp_data_reg;

    // modify stage logic
    line_state_t       ram_rd_data;
    line_state_t       cur_state;
    line_state_t       new_state;
    logic              s1_commit;
    logic              s1_wr;
    logic [BYTE_W-1:0] res_read_data;
    logic              res_bus_error;
    logic              res_tx_valid;
    logic [BYTE_W-1:0] res_tx_byte;

    // interrupt mirrors for the lines that have irq outputs
    logic [IRQ_W-1:0]  rx_irq_reg;
    logic [IRQ_W-1:0]  tx_irq_reg;
    logic [IRQ_W-1:0]  rx_irq_next;
    logic [IRQ_W-1:0]  tx_irq_next;
    logic [IRQ_W-1:0]  present_mask;

    // output register
    logic              out_valid_reg;
    logic [BYTE_W-1:0] read_data_reg;
    logic              bus_error_reg;
    logic              tx_valid_reg;
    logic [BYTE_W-1:0] tx_byte_reg;
    logic [IRQ_W-1:0]  rx_irq_out_reg;
    logic [IRQ_W-1:0]  tx_irq_out_reg;

    // configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_count_reg <= TERM_COUNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            term_count_reg <= cfg_wr_data;
        end
    end

    // handshake: the modify stage moves on when the output register is free
    assign s1_commit = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_commit;
    assign in_xfer   = in_valid && !in_stall;

    // line presence checks
    assign bus_line    = address[ADDR_W-1:OFS_W];
    assign bus_ofs     = address[OFS_W-1:0];
    assign count_ext   = LINE_W'(term_count_reg);
    assign bus_line_ok = (bus_line < count_ext) && (bus_line < LINE_W'(MAX_LINES));
    assign ev_line_ok  = (LINE_W'(line_index) < count_ext)
                      && (LINE_W'(line_index) < LINE_W'(MAX_LINES));

    // decode the item into an operation on one line
    always_comb
    begin
        dec_op   = OP_NONE;
        dec_line = bus_line;
        dec_byte = write_data[BYTE_W-1:0];
        case (kind)
            KIND_READ:
            begin
                if (!bus_line_ok)
                begin
                    dec_op = OP_ERROR;
                end
                else
                begin
                    case (bus_ofs)
                        OFS_RX_CTRL: dec_op = OP_RD_RXC;
                        OFS_RX_DATA: dec_op = OP_RD_RXD;
                        OFS_TX_CTRL: dec_op = OP_RD_TXC;
                        default:     dec_op = OP_ERROR;
                    endcase
                end
            end
            KIND_WRITE:
            begin
                if (!bus_line_ok)
                begin
                    dec_op = OP_ERROR;
                end
                else
                begin
                    case (bus_ofs)
                        OFS_RX_CTRL: dec_op = OP_WR_RXC;
                        OFS_TX_CTRL: dec_op = OP_WR_TXC;
                        OFS_TX_DATA: dec_op = OP_WR_TXD;
                        default:     dec_op = OP_ERROR;
                    endcase
                end
            end
            KIND_RX_CHAR:
            begin
                dec_line = LINE_W'(line_index);
                dec_byte = rx_char;
                dec_op   = ev_line_ok ? OP_EV_RX : OP_NONE;
            end
            KIND_TX_DONE:
            begin
                dec_line = LINE_W'(line_index);
                dec_op   = ev_line_ok ? OP_EV_TXD : OP_NONE;
            end
            default:
            begin
                dec_op = OP_NONE;
            end
        endcase
    end

    assign dec_idx = dec_line[IDX_W-1:0];

    // line state ram
    stru_line_ram #(
        .DEPTH (MAX_LINES),
        .IDX_W (IDX_W)
    ) u_line_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_xfer),
        .rd_idx  (dec_idx),
        .rd_data (ram_rd_data),
        .wr_en   (s1_wr),
        .wr_idx  (s1_idx_reg),
        .wr_data (new_state)
    );

    // bypass when the item ahead writes the line this one reads in the same cycle
    assign byp_valid_next = s1_wr && (s1_idx_reg == dec_idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_op_reg     <= OP_NONE;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                s1_valid_reg  <= 1'b1;
                s1_op_reg     <= dec_op;
                byp_valid_reg <= byp_valid_next;
            end
            else if (s1_commit)
            begin
                s1_valid_reg  <= 1'b0;
            end
        end
    end

    // modify stage payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_line_reg  <= dec_line;
            s1_idx_reg   <= dec_idx;
            s1_byte_reg  <= dec_byte;
            byp_data_reg <= new_state;
        end
    end

    assign cur_state = byp_valid_reg ? byp_data_reg : ram_rd_data;

    // read-modify of the selected line
    always_comb
    begin
        new_state     = cur_state;
        s1_wr         = 1'b0;
        res_read_data = '0;
        res_bus_error = 1'b0;
        res_tx_valid  = 1'b0;
        res_tx_byte   = '0;
        case (s1_op_reg)
            OP_ERROR:
            begin
                res_bus_error = 1'b1;
            end
            OP_RD_RXC:
            begin
                res_read_data[BIT_RDY] = cur_state.rx_ready;
                res_read_data[BIT_IEN] = cur_state.rx_int_enable;
            end
            OP_RD_RXD:
            begin
                res_read_data      = cur_state.rx_byte;
                new_state.rx_ready = 1'b0;
                s1_wr              = 1'b1;
            end
            OP_RD_TXC:
            begin
                res_read_data[BIT_RDY] = cur_state.tx_ready;
                res_read_data[BIT_IEN] = cur_state.tx_int_enable;
            end
            OP_WR_RXC:
            begin
                new_state.rx_ready      = s1_byte_reg[BIT_RDY];
                new_state.rx_int_enable = s1_byte_reg[BIT_IEN];
                s1_wr                   = 1'b1;
            end
            OP_WR_TXC:
            begin
                new_state.tx_ready      = s1_byte_reg[BIT_RDY];
                new_state.tx_int_enable = s1_byte_reg[BIT_IEN];
                s1_wr                   = 1'b1;
            end
            OP_WR_TXD:
            begin
                new_state.tx_byte_held = s1_byte_reg;
                new_state.tx_ready     = 1'b0;
                s1_wr                  = 1'b1;
            end
            OP_EV_RX:
            begin
                new_state.rx_byte  = s1_byte_reg;
                new_state.rx_ready = 1'b1;
                s1_wr              = 1'b1;
            end
            OP_EV_TXD:
            begin
                res_tx_valid       = 1'b1;
                res_tx_byte        = cur_state.tx_byte_held;
                new_state.tx_ready = 1'b1;
                s1_wr              = 1'b1;
            end
            default:
            begin
                s1_wr = 1'b0;
            end
        endcase
        s1_wr = s1_wr && s1_commit;
    end

    // interrupt mirrors follow each write to a low line
    always_comb
    begin
        rx_irq_next = rx_irq_reg;
        tx_irq_next = tx_irq_reg;
        for (int i = 0; i < IRQ_W; i++)
        begin
            present_mask[i] = (LINE_W'(i) < count_ext) && (i < MAX_LINES);
            if (s1_wr && (s1_line_reg == LINE_W'(i)))
            begin
                rx_irq_next[i] = new_state.rx_ready && new_state.rx_int_enable;
                tx_irq_next[i] = new_state.tx_ready && new_state.tx_int_enable;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_irq_reg <= '0;
            tx_irq_reg <= '0;
        end
        else
        begin
            rx_irq_reg <= rx_irq_next;
            tx_irq_reg <= tx_irq_next;
        end
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (s1_commit)
        begin
            read_data_reg  <= res_read_data;
            bus_error_reg  <= res_bus_error;
            tx_valid_reg   <= res_tx_valid;
            tx_byte_reg    <= res_tx_byte;
            rx_irq_out_reg <= rx_irq_next & present_mask;
            tx_irq_out_reg <= tx_irq_next & present_mask;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_data    = read_data_reg;
    assign bus_error    = bus_error_reg;
    assign tx_valid     = tx_valid_reg;
    assign tx_byte      = tx_byte_reg;
    assign rx_irq_lines = rx_irq_out_reg;
    assign tx_irq_lines = tx_irq_out_reg;

    // checks
    `STRU_ASSERT(a_stall_only_when_busy, in_stall |-> s1_valid_reg, "input stalled with empty modify stage")
    `STRU_ASSERT_NEVER(a_tx_without_error, out_valid && tx_valid && bus_error, "transmit byte on an error result")
    `STRU_ASSERT(a_error_reads_zero, (out_valid && bus_error) |-> (read_data == '0), "error result carries read data")
    `STRU_ASSERT(a_no_write_without_commit, s1_wr |-> (s1_valid_reg && !(out_valid_reg && out_stall)), "line ram written while the result cannot move")

endmodule
